// ===== design/assert_macros.svh =====
// assertion macros shared by the mixer modules
// expects clk and arst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define VMI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition implies a consequence in the next cycle
`define VMI_ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

// ===== design/vmi_pkg.sv =====
// shared types and constants of the interpolating voice mixer
// no dependencies
`timescale 1ns / 1ps

package vmi_pkg;

	localparam int NUM_VOICES   = 16;
	localparam int VOICE_W      = $clog2(NUM_VOICES);
	localparam int SAMPLE_DEPTH = 65536;
	localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
	localparam int ACC_W        = 56;

	localparam logic CFG_MASTER_GAIN = 1'b0;
	localparam logic CFG_SOUND_GAIN  = 1'b1;

	typedef enum logic [2:0] {
		OP_LOAD  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_PAUSE = 3'd3,
		OP_FRAME = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic [15:0]        mem_address;
		logic signed [15:0] sample_value;
		logic [3:0]         voice_index;
		logic [15:0]        length_frames;
		logic               stereo_source;
		logic               loop_enable;
		logic [15:0]        volume;
		logic signed [15:0] pan;
		logic [19:0]        pitch_step;
		logic               pause_request;
	} mix_req_t;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic [4:0]         voice_count;
	} mix_res_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_WRITE, S_ST1, S_ST2, S_ST3, S_STOP, S_PAUSE,
		S_FS1, S_FS2, S_CHK, S_RD0, S_RD1, S_GN, S_IV, S_ML, S_MH, S_AC,
		S_GA, S_GB, S_ADV, S_OUT
	} state_t;

	typedef enum logic [4:0] {
		CMD_NOP, CMD_WRITE, CMD_START1, CMD_START2, CMD_START3, CMD_STOP,
		CMD_PAUSE, CMD_SCALE1, CMD_SCALE2, CMD_CHECK, CMD_READ0, CMD_READ1,
		CMD_GAIN, CMD_INTERP, CMD_MUL_LO, CMD_MUL_HI, CMD_ACCUM, CMD_GMUL,
		CMD_GRND, CMD_ADVANCE, CMD_OUTPUT
	} cmd_op_t;

	typedef struct packed {
		logic               accept;
		cmd_op_t            op;
		logic [VOICE_W-1:0] voice;
		logic               ch;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       play;
		logic       stereo;
	} dp_status_t;

endpackage

// ===== design/vmi_ctrl.sv =====
// sequencer of the voice mixer: request decode, voice and channel loop
// depends on vmi_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vmi_ctrl
	import vmi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t             state_q, state_d;
	logic [VOICE_W-1:0] vc_q;
	logic               ch_q;
	logic               last;

	assign last = (vc_q == VOICE_W'(NUM_VOICES - 1));
	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vc_q    <= '0;
			ch_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_FS2: vc_q <= '0;
				S_CHK: begin
					ch_q <= 1'b0;
					if (!status.play && !last) vc_q <= vc_q + 1'b1;
				end
				S_AC: if (!ch_q) ch_q <= 1'b1;
				S_ADV: if (!last) vc_q <= vc_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_DECODE;
			S_DECODE: begin
				case (status.op)
					OP_LOAD:  state_d = S_WRITE;
					OP_START: state_d = S_ST1;
					OP_STOP:  state_d = S_STOP;
					OP_PAUSE: state_d = S_PAUSE;
					OP_FRAME: state_d = S_FS1;
					default:  state_d = S_IDLE;
				endcase
			end
			S_WRITE, S_STOP, S_PAUSE, S_ST3, S_OUT: state_d = S_IDLE;
			S_ST1: state_d = S_ST2;
			S_ST2: state_d = S_ST3;
			S_FS1: state_d = S_FS2;
			S_FS2: state_d = S_CHK;
			S_CHK: begin
				if (status.play) state_d = S_RD0;
				else if (last) state_d = S_OUT;
				else state_d = S_CHK;
			end
			S_RD0: state_d = S_RD1;
			S_RD1: state_d = S_GN;
			S_GN:  state_d = S_IV;
			S_IV:  state_d = S_ML;
			S_ML:  state_d = S_MH;
			S_MH:  state_d = S_AC;
			S_AC: begin
				if (ch_q) state_d = S_ADV;
				else if (status.stereo) state_d = S_RD0;
				else state_d = S_GA;
			end
			S_GA: state_d = S_GB;
			S_GB: state_d = S_ML;
			S_ADV: state_d = last ? S_OUT : S_CHK;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.accept = (state_q == S_IDLE) && start;
		cmd.voice  = vc_q;
		cmd.ch     = ch_q;
		case (state_q)
			S_WRITE: cmd.op = CMD_WRITE;
			S_ST1:   cmd.op = CMD_START1;
			S_ST2:   cmd.op = CMD_START2;
			S_ST3:   cmd.op = CMD_START3;
			S_STOP:  cmd.op = CMD_STOP;
			S_PAUSE: cmd.op = CMD_PAUSE;
			S_FS1:   cmd.op = CMD_SCALE1;
			S_FS2:   cmd.op = CMD_SCALE2;
			S_CHK:   cmd.op = CMD_CHECK;
			S_RD0:   cmd.op = CMD_READ0;
			S_RD1:   cmd.op = CMD_READ1;
			S_GN:    cmd.op = CMD_GAIN;
			S_IV:    cmd.op = CMD_INTERP;
			S_ML:    cmd.op = CMD_MUL_LO;
			S_MH:    cmd.op = CMD_MUL_HI;
			S_AC:    cmd.op = CMD_ACCUM;
			S_GA:    cmd.op = CMD_GMUL;
			S_GB:    cmd.op = CMD_GRND;
			S_ADV:   cmd.op = CMD_ADVANCE;
			S_OUT:   cmd.op = CMD_OUTPUT;
			default: cmd.op = CMD_NOP;
		endcase
	end

	`VMI_ASSERT_NEXT(a_out_to_idle, state_q == S_OUT, state_q == S_IDLE, "frame end not idle")
	`VMI_ASSERT_NEXT(a_right_done, state_q == S_AC && ch_q, state_q == S_ADV,
		"voice not advanced after right channel")
	`VMI_ASSERT(a_accept_idle, cmd.accept |-> !busy, "request taken while busy")

endmodule

// ===== design/vmi_datapath.sv =====
// datapath of the voice mixer: sample memory, voice registers, shared multiplier
// depends on vmi_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vmi_datapath
	import vmi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  mix_req_t   request,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [15:0] cfg_wdata,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output mix_res_t   result,
	output logic       done
);

	logic [15:0] mem_q [SAMPLE_DEPTH];
	logic [15:0] rdata_q;
	logic [ADDR_W-1:0] raddr;

	logic        active_q  [NUM_VOICES];
	logic        paused_q  [NUM_VOICES];
	logic        looping_q [NUM_VOICES];
	logic        stereo_q  [NUM_VOICES];
	logic [15:0] base_q    [NUM_VOICES];
	logic [15:0] length_q  [NUM_VOICES];
	logic [19:0] position_q[NUM_VOICES];
	logic [15:0] phase_q   [NUM_VOICES];
	logic [19:0] step_q    [NUM_VOICES];
	logic [16:0] lgain_q   [NUM_VOICES];
	logic [16:0] rgain_q   [NUM_VOICES];

	mix_req_t    req_q;
	logic [15:0] master_q, sound_q;
	logic [16:0] scale_q;
	logic [18:0] g_q;
	logic signed [15:0] s0_q;
	logic signed [32:0] v_q;
	logic [15:0] pos_q, nxt_q;
	logic signed [ACC_W-1:0] accl_q, accr_q;
	logic [4:0]  count_q;
	logic signed [39:0] p_q;
	mix_res_t    result_q;
	logic        done_q;

	logic signed [19:0] ma, mb;
	logic signed [19:0] lf, rf;
	logic [VOICE_W-1:0] v;
	logic [VOICE_W-1:0] rv;
	logic        elig, pos_ge, play;
	logic [15:0] pos_eff, nxt_eff;
	logic [16:0] pos_inc;
	logic [16:0] gain_c;
	logic signed [16:0] diff;
	logic [20:0] t;
	logic signed [ACC_W-1:0] acc_c, acc_sum;
	logic signed [15:0] sat_l, sat_r;

	function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] r;
		begin
			r = (a + (ACC_W'(1) <<< 30)) >>> 31;
			if (r > ACC_W'(32767)) sat16 = 16'sh7fff;
			else if (r < -ACC_W'(32768)) sat16 = -16'sh8000;
			else sat16 = r[15:0];
		end
	endfunction

	assign v  = cmd.voice;
	assign rv = req_q.voice_index;

	assign elig    = active_q[v] && !paused_q[v];
	assign pos_ge  = position_q[v] >= {4'b0, length_q[v]};
	assign play    = elig && (length_q[v] != 16'd0) && (!pos_ge || looping_q[v]);
	assign pos_eff = pos_ge ? 16'd0 : position_q[v][15:0];
	assign pos_inc = {1'b0, pos_eff} + 17'd1;
	assign nxt_eff = (pos_inc == {1'b0, length_q[v]}) ? 16'd0 : pos_inc[15:0];

	assign status.op     = req_q.operation;
	assign status.play   = play;
	assign status.stereo = stereo_q[v];

	assign gain_c = cmd.ch ? rgain_q[v] : lgain_q[v];
	assign diff   = 17'(signed'(rdata_q)) - 17'(s0_q);
	assign lf     = 20'sd65536 - 20'(req_q.pan);
	assign rf     = 20'sd65536 + 20'(req_q.pan);
	assign t      = {5'b0, phase_q[v]} + {1'b0, step_q[v]};
	assign acc_c  = cmd.ch ? accr_q : accl_q;

	always_comb begin
		acc_sum = acc_c;
		case (cmd.op)
			CMD_MUL_HI: acc_sum = acc_c + ACC_W'(p_q);
			CMD_ACCUM:  acc_sum = acc_c + (ACC_W'(p_q) <<< 16);
			default:    acc_sum = acc_c;
		endcase
	end

	always_comb begin
		if (cmd.op == CMD_READ0) begin
			raddr = stereo_q[v] ? base_q[v] + {pos_q[14:0], 1'b0} + 16'(cmd.ch)
				: base_q[v] + pos_q;
		end else begin
			raddr = stereo_q[v] ? base_q[v] + {nxt_q[14:0], 1'b0} + 16'(cmd.ch)
				: base_q[v] + nxt_q;
		end
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			CMD_START1: begin ma = {4'b0, req_q.volume}; mb = lf; end
			CMD_START2: begin ma = {4'b0, req_q.volume}; mb = rf; end
			CMD_SCALE1: begin ma = {4'b0, master_q}; mb = {4'b0, sound_q}; end
			CMD_READ1, CMD_GMUL: begin ma = {3'b0, gain_c}; mb = {3'b0, scale_q}; end
			CMD_GAIN:   begin ma = 20'(diff); mb = {4'b0, phase_q[v]}; end
			CMD_MUL_LO: begin ma = {4'b0, v_q[15:0]}; mb = {1'b0, g_q}; end
			CMD_MUL_HI: begin ma = 20'(signed'(v_q[32:16])); mb = {1'b0, g_q}; end
			default: ;
		endcase
	end

	assign sat_l = sat16(accl_q);
	assign sat_r = sat16(accr_q);

	always_ff @(posedge clk) begin
		if (cmd.op == CMD_WRITE) mem_q[req_q.mem_address] <= req_q.sample_value;
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk) begin
		p_q <= ma * mb;
		if (cmd.accept) req_q <= request;
		case (cmd.op)
			CMD_START1: begin
				looping_q[rv]  <= req_q.loop_enable;
				stereo_q[rv]   <= req_q.stereo_source;
				base_q[rv]     <= req_q.mem_address;
				length_q[rv]   <= req_q.length_frames;
				position_q[rv] <= '0;
				phase_q[rv]    <= '0;
				step_q[rv]     <= req_q.pitch_step;
			end
			CMD_START2: lgain_q[rv] <= 17'((p_q + 40'sd32768) >>> 16);
			CMD_START3: rgain_q[rv] <= 17'((p_q + 40'sd32768) >>> 16);
			CMD_SCALE2: begin
				scale_q <= 17'((p_q + 40'sd16384) >>> 15);
				accl_q  <= '0;
				accr_q  <= '0;
			end
			CMD_CHECK: begin
				pos_q <= pos_eff;
				nxt_q <= nxt_eff;
			end
			CMD_READ1: s0_q <= signed'(rdata_q);
			CMD_GAIN, CMD_GRND: g_q <= 19'((p_q + 40'sd16384) >>> 15);
			CMD_INTERP: v_q <= 33'(40'(s0_q) * 40'sd65536 + p_q);
			CMD_MUL_HI, CMD_ACCUM: begin
				if (cmd.ch) accr_q <= acc_sum;
				else accl_q <= acc_sum;
			end
			CMD_ADVANCE: begin
				position_q[v] <= {4'b0, pos_q} + {15'b0, t[20:16]};
				phase_q[v]    <= t[15:0];
			end
			CMD_OUTPUT: begin
				result_q.left_sample  <= sat_l;
				result_q.right_sample <= sat_r;
				result_q.voice_count  <= count_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				active_q[i] <= 1'b0;
				paused_q[i] <= 1'b0;
			end
			master_q <= 16'd32768;
			sound_q  <= 16'd32768;
			count_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (cmd.op == CMD_OUTPUT);
			if (cfg_we) begin
				case (cfg_index)
					CFG_MASTER_GAIN: master_q <= cfg_wdata;
					CFG_SOUND_GAIN:  sound_q  <= cfg_wdata;
					default: ;
				endcase
			end
			case (cmd.op)
				CMD_START1: begin
					active_q[rv] <= 1'b1;
					paused_q[rv] <= 1'b0;
				end
				CMD_STOP:  active_q[rv] <= 1'b0;
				CMD_PAUSE: paused_q[rv] <= req_q.pause_request;
				CMD_SCALE2: count_q <= '0;
				CMD_CHECK: begin
					if (elig) begin
						count_q <= count_q + 5'd1;
						if (!play) active_q[v] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign result = result_q;
	assign done   = done_q;

	`VMI_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "result strobe longer than one cycle")
	`VMI_ASSERT(a_count_range, done_q |-> (result_q.voice_count <= 5'(NUM_VOICES)),
		"active count above voice count")
	`VMI_ASSERT(a_count_bound, count_q <= 5'(NUM_VOICES), "voice counter above voice count")

endmodule

// ===== design/voice_mixer_interpolating.sv =====
// top level of the interpolating multi-voice sample mixer
// depends on vmi_pkg, vmi_ctrl and vmi_datapath
//
// channel   | direction | handshake
// request   | in        | taken when start high and busy low
// config    | in        | written when cfg_we high
// result    | out       | valid for one cycle while done high
//
// a frame visits every voice in turn and mixes each playing mono or stereo voice;
// one shared 20x20 multiplier and one memory read port set the per-voice length
// reset clears the active and pause flags of every voice and sets both gains to unity
// results cannot be held off by the receiver
`timescale 1ns / 1ps

module voice_mixer_interpolating
	import vmi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  mix_req_t    request,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	output mix_res_t    result,
	output logic        done
);

	dp_cmd_t    cmd;
	dp_status_t status;

	vmi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	vmi_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.result    (result),
		.done      (done)
	);

endmodule

// ===== test/voice_mixer_interpolating_tb.sv =====
// self-checking testbench of the interpolating voice mixer
// depends on vmi_pkg and voice_mixer_interpolating; mixes are predicted in the bench
`timescale 1ns / 1ps

module voice_mixer_interpolating_tb;
	import vmi_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	mix_req_t    request = '0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_MASTER_GAIN;
	logic [15:0] cfg_wdata = '0;
	mix_res_t    result;
	logic        done;

	voice_mixer_interpolating u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.result(result), .done(done)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mirror of the mixer state
	logic signed [15:0] wave_mem [SAMPLE_DEPTH];
	bit          v_active [NUM_VOICES];
	bit          v_paused [NUM_VOICES];
	bit          v_loop [NUM_VOICES];
	bit          v_stereo [NUM_VOICES];
	logic [15:0] v_base [NUM_VOICES];
	logic [15:0] v_len [NUM_VOICES];
	logic [19:0] v_pos [NUM_VOICES];
	logic [15:0] v_phase [NUM_VOICES];
	logic [19:0] v_step [NUM_VOICES];
	logic [16:0] v_lgain [NUM_VOICES];
	logic [16:0] v_rgain [NUM_VOICES];
	logic [15:0] master_gain = 16'd32768;
	logic [15:0] sound_gain = 16'd32768;

	mix_req_t pending_reqs[$];
	mix_res_t mix_expect[$];
	int       errors = 0;
	int       accepted = 0;
	int       idle_cycles = 0;
	logic     taken;

	function automatic longint word_at(longint addr);
		return longint'(wave_mem[addr[15:0]]);
	endfunction

	function automatic longint blend(longint a0, longint a1, longint f);
		return word_at(a0) * (65536 - f) + word_at(a1) * f;
	endfunction

	function automatic logic [15:0] saturate(longint acc);
		longint r;
		r = (acc + (longint'(1) << 30)) >>> 31;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic mix_res_t mix_frame();
		mix_res_t res;
		longint accl = 0, accr = 0, scale, gl, gr, s, pos, nxt, len, base, f, t;
		int cnt = 0;
		scale = (longint'(master_gain) * longint'(sound_gain) + 16384) >> 15;
		for (int i = 0; i < NUM_VOICES; i++) begin
			if (!v_active[i] || v_paused[i]) continue;
			cnt++;
			len = longint'(v_len[i]);
			pos = longint'(v_pos[i]);
			if (len == 0) begin
				v_active[i] = 1'b0;
				continue;
			end
			if (pos >= len) begin
				if (v_loop[i]) begin
					pos = 0;
				end else begin
					v_active[i] = 1'b0;
					continue;
				end
			end
			nxt = (pos + 1) % len;
			base = longint'(v_base[i]);
			f = longint'(v_phase[i]);
			gl = (longint'(v_lgain[i]) * scale + 16384) >> 15;
			gr = (longint'(v_rgain[i]) * scale + 16384) >> 15;
			if (v_stereo[i]) begin
				accl += blend(base + 2 * pos, base + 2 * nxt, f) * gl;
				accr += blend(base + 2 * pos + 1, base + 2 * nxt + 1, f) * gr;
			end else begin
				s = blend(base + pos, base + nxt, f);
				accl += s * gl;
				accr += s * gr;
			end
			t = f + longint'(v_step[i]);
			v_pos[i] = 20'(pos + (t >> 16));
			v_phase[i] = t[15:0];
		end
		res.left_sample = saturate(accl);
		res.right_sample = saturate(accr);
		res.voice_count = (cnt > 31) ? 5'd31 : 5'(cnt);
		return res;
	endfunction

	function automatic void apply_request(mix_req_t r);
		int v;
		longint vol, pan;
		v = int'(r.voice_index);
		case (r.operation)
			OP_LOAD: wave_mem[r.mem_address] = r.sample_value;
			OP_START: begin
				vol = longint'(r.volume);
				pan = longint'(r.pan);
				v_active[v] = 1'b1;
				v_paused[v] = 1'b0;
				v_loop[v] = r.loop_enable;
				v_stereo[v] = r.stereo_source;
				v_base[v] = r.mem_address;
				v_len[v] = r.length_frames;
				v_pos[v] = '0;
				v_phase[v] = '0;
				v_step[v] = r.pitch_step;
				v_lgain[v] = 17'((vol * (65536 - pan) + 32768) >> 16);
				v_rgain[v] = 17'((vol * (65536 + pan) + 32768) >> 16);
			end
			OP_STOP: v_active[v] = 1'b0;
			OP_PAUSE: v_paused[v] = r.pause_request;
			OP_FRAME: mix_expect.push_back(mix_frame());
			default: ;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				apply_request(request);
				accepted++;
			end
			if (!start || taken) begin
				if (pending_reqs.size() > 0 && ((accepted > 500 && accepted < 800)
						|| $urandom_range(99) >= 26)) begin
					request <= pending_reqs.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (mix_expect.size() == 0) begin
				$error("unexpected result %p", result);
				errors++;
			end else begin
				mix_res_t e;
				e = mix_expect.pop_front();
				if (result.left_sample !== e.left_sample) begin
					$error("left_sample exp %0d got %0d", e.left_sample, result.left_sample);
					errors++;
				end
				if (result.right_sample !== e.right_sample) begin
					$error("right_sample exp %0d got %0d", e.right_sample, result.right_sample);
					errors++;
				end
				if (result.voice_count !== e.voice_count) begin
					$error("voice_count exp %0d got %0d", e.voice_count, result.voice_count);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[voice_mixer_interpolating] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic mix_req_t any_req(op_t op);
		mix_req_t r;
		logic [127:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom};
		r = bits[$bits(mix_req_t)-1:0];
		r.operation = op;
		return r;
	endfunction

	function automatic mix_req_t start_req(int v, int base, int len, bit st, bit lp,
			int vol, int pan, int step);
		mix_req_t r;
		r = any_req(OP_START);
		r.voice_index = 4'(v);
		r.mem_address = 16'(base);
		r.length_frames = 16'(len);
		r.stereo_source = st;
		r.loop_enable = lp;
		r.volume = 16'(vol);
		r.pan = 16'(pan);
		r.pitch_step = 20'(step);
		return r;
	endfunction

	// sounds start in the low 64 words or the top 16 words, so every read
	// lands in the filled words 0 to 255 or 65520 to 65535
	function automatic mix_req_t rand_req();
		mix_req_t r;
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			r = any_req(OP_FRAME);
		end else if (pick < 65) begin
			r = any_req(OP_START);
			case ($urandom_range(9))
				0: r.length_frames = '0;
				1: r.length_frames = 16'd1;
				2: r.length_frames = 16'd64;
				default: r.length_frames = 16'($urandom_range(64, 1));
			endcase
			if ($urandom_range(1) != 0) r.mem_address = 16'($urandom_range(63));
			else r.mem_address = 16'(32'hfff0 + $urandom_range(15));
			if ($urandom_range(4) != 0) r.pitch_step = 20'($urandom_range(32'h3ffff));
			if ($urandom_range(5) != 0) r.volume = 16'($urandom_range(32768));
		end else if (pick < 73) begin
			r = any_req(OP_STOP);
		end else if (pick < 83) begin
			r = any_req(OP_PAUSE);
		end else if (pick < 95) begin
			r = any_req(OP_LOAD);
		end else begin
			r = any_req(OP_FRAME);
			r.operation = 3'($urandom_range(7, 5));
		end
		return r;
	endfunction

	task automatic drain();
		while (pending_reqs.size() > 0 || start || mix_expect.size() > 0 || busy)
			@(negedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_gains(logic [15:0] mg, logic [15:0] sg);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MASTER_GAIN;
		cfg_wdata <= mg;
		@(posedge clk);
		master_gain = mg;
		cfg_index <= CFG_SOUND_GAIN;
		cfg_wdata <= sg;
		@(posedge clk);
		sound_gain = sg;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		mix_req_t r;
		logic [15:0] gains [4][2];
		gains = '{'{16'd32768, 16'd32768}, '{16'hffff, 16'hffff}, '{16'd0, 16'd32768},
			'{16'd20000, 16'd9000}};
		for (int i = 0; i < NUM_VOICES; i++) begin
			v_active[i] = 1'b0;
			v_paused[i] = 1'b0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_gains(16'd32768, 16'd32768);

		// words 0 to 255 and 65520 to 65535 hold every sound
		for (int a = 0; a < 272; a++) begin
			r = any_req(OP_LOAD);
			r.mem_address = (a < 256) ? 16'(a) : 16'(65264 + a);
			if (a == 0) r.sample_value = 16'sh7fff;
			if (a == 1) r.sample_value = 16'sh8000;
			if (a == 2) r.sample_value = 16'sh7fff;
			if (a == 3) r.sample_value = 16'sh8000;
			pending_reqs.push_back(r);
		end

		// directed
		pending_reqs.push_back(any_req(OP_FRAME));
		pending_reqs.push_back(start_req(0, 0, 4, 1, 1, 32768, -32768, 20'h0c000));
		pending_reqs.push_back(start_req(15, 65535, 3, 0, 0, 65535, 32767, 20'hfffff));
		pending_reqs.push_back(start_req(1, 65534, 40, 1, 0, 32768, 0, 20'h08000));
		pending_reqs.push_back(start_req(2, 5, 0, 0, 1, 32768, 0, 20'h10000));
		pending_reqs.push_back(start_req(3, 0, 1, 0, 1, 0, 0, 20'h00001));
		pending_reqs.push_back(any_req(OP_FRAME));
		pending_reqs.push_back(any_req(OP_FRAME));
		r = any_req(OP_PAUSE); r.voice_index = 4'd0; r.pause_request = 1'b1;
		pending_reqs.push_back(r);
		r = any_req(OP_PAUSE); r.voice_index = 4'd9; r.pause_request = 1'b1;
		pending_reqs.push_back(r);
		pending_reqs.push_back(any_req(OP_FRAME));
		r = any_req(OP_PAUSE); r.voice_index = 4'd0; r.pause_request = 1'b0;
		pending_reqs.push_back(r);
		pending_reqs.push_back(start_req(9, 100, 8, 0, 0, 32768, 0, 20'h10000));
		r = any_req(OP_STOP); r.voice_index = 4'd3;
		pending_reqs.push_back(r);
		for (int k = 5; k <= 7; k++) begin
			r = any_req(OP_FRAME); r.operation = 3'(k);
			pending_reqs.push_back(r);
		end
		repeat (5) pending_reqs.push_back(any_req(OP_FRAME));

		for (int p = 0; p < 4; p++) begin
			drain();
			set_gains(gains[p][0], gains[p][1]);
			repeat (330) pending_reqs.push_back(rand_req());
		end
		drain();
		repeat (40) @(posedge clk);
		if (mix_expect.size() != 0) errors++;
		if (errors == 0)
			$display("[voice_mixer_interpolating] OK");
		else
			$display("[voice_mixer_interpolating] ERROR");
		$finish;
	end

endmodule
